/* rtl/rcfp_pkg.sv */
// Package for the RC link frame parser: shared types and fixed constants.
// No dependencies.
`default_nettype none
package rcfp_pkg;

  localparam int MIN_LEN  = 3;   // smallest legal declared length
  localparam int NUM_CH   = 16;  // channels per channels frame
  localparam int CH_BITS  = 11;  // bits per channel
  localparam int CH_BYTES = 22;  // packed channel payload bytes
  localparam int MAX_RUNS = 2;   // channel runs per received byte

  // configuration register indexes
  localparam logic [1:0] CFG_RX_ADDR = 2'd0;
  localparam logic [1:0] CFG_CH_TYPE = 2'd1;
  localparam logic [1:0] CFG_CRC_POLY = 2'd2;

  typedef struct packed {
    logic [7:0] rx_addr;
    logic [7:0] ch_type;
    logic [7:0] crc_poly;
  } cfg_t;

  // head of the byte queue as seen by the scanner
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } q_head_t;

endpackage
`default_nettype wire

/* rtl/rc_link_frame_parser_unit.sv */
// Top level of the RC link frame parser: configuration registers, byte queue,
// scanner back end. Depends on rcfp_pkg, rcfp_front, rcfp_back, rcfp_ram.
`default_nettype none
// Byte-serial parser for CRSF-style RC frames. Each received byte is queued,
// appended to a circular frame buffer in RAM and the buffer is rescanned:
// bad length drops one byte, CRC mismatch drops one byte, a good frame is
// consumed whole, and a good channels frame for our address yields sixteen
// 11-bit channel transactions (index, value, last flag). Per byte the scanner
// takes the byte from the queue, then reads the address and length bytes once
// two are buffered; a complete frame adds the CRC walk, the check and the
// rescan (one byte per cycle through the single RAM read port), and a
// channels frame adds the unpack, which reads payload bytes and sends the
// channels out, waiting while the receiver stalls. Each drop restarts the
// scan. A two-byte queue lets the link keep sending while the scanner works;
// the output register lets the next channel be prepared while one waits.
// Buffer needs no clearing after reset.
module rc_link_frame_parser_unit import rcfp_pkg::*; #(
  parameter int BUFFER_BYTES = 64,
  parameter int MAX_PAYLOAD  = 60
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       channel_index_o,
  output logic [10:0]      channel_value_o,
  output logic             last_channel_o
);
  cfg_t    cfg_q;
  q_head_t q_head;
  logic    pop;

  // register writes; index beyond the list is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rx_addr  <= 8'd200;
      cfg_q.ch_type  <= 8'd22;
      cfg_q.crc_poly <= 8'd213;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RX_ADDR:  cfg_q.rx_addr  <= cfg_data_i;
        CFG_CH_TYPE:  cfg_q.ch_type  <= cfg_data_i;
        CFG_CRC_POLY: cfg_q.crc_poly <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rcfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i (rx_byte_i),
    .head_o    (q_head),
    .pop_i     (pop)
  );

  rcfp_back #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .head_i         (q_head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .last_channel_o (last_channel_o)
  );
endmodule
`default_nettype wire

/* rtl/rcfp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rcfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/rcfp_front.sv */
// Front end: accepts received bytes into a two-entry queue for the scanner.
// Depends on rcfp_pkg.
`default_nettype none
module rcfp_front import rcfp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output q_head_t         head_o,
  input  wire logic       pop_i
);
  logic [7:0] data_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.data  = data_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      data_q[wr_ptr_q] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/rcfp_back.sv */
// Back end: frame buffer in RAM, rescan engine, CRC walk and channel unpack.
// Depends on rcfp_pkg and rcfp_ram.
`default_nettype none
module rcfp_back import rcfp_pkg::*; #(
  parameter int BUFFER_BYTES = 64,
  parameter int MAX_PAYLOAD  = 60
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire cfg_t        cfg_i,
  input  wire q_head_t     head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       channel_index_o,
  output logic [10:0]      channel_value_o,
  output logic             last_channel_o
);
  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = $clog2(BUFFER_BYTES + 1);
  localparam int SW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ADDR, S_LEN, S_CRC, S_CHK, S_EM_RD, S_EM_LD, S_EM_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] off_q, off_d;
  logic [7:0]    len_q, len_d, addr_q, addr_d, type_q, type_d, crc_q, crc_d;
  logic [18:0]   acc_q, acc_d;
  logic [4:0]    bits_q, bits_d;
  logic [3:0]    k_q, k_d;
  logic [1:0]    runs_q, runs_d;
  logic          ov_q, ov_d, last_q, last_d;
  logic [3:0]    oidx_q, oidx_d;
  logic [10:0]   oval_q, oval_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata;
  logic          drop_one, drop_frame;
  logic [CW-1:0] drop_n, frame_n;
  logic          len_bad;
  logic [4:0]    bits_ld;
  logic [18:0]   acc_ld;

  function automatic logic [AW-1:0] ptr(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(BUFFER_BYTES)) s = s - SW'(BUFFER_BYTES);
    return s[AW-1:0];
  endfunction

  // one byte of MSB-first CRC-8
  function automatic logic [7:0] crc_byte(input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] poly);
    logic [7:0] r;
    r = c ^ d;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  rcfp_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(head_i.data),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign len_bad = (int'(rdata) < MIN_LEN) || (int'(rdata) > MAX_PAYLOAD + 2)
                || (int'(rdata) + 2 > BUFFER_BYTES);
  assign frame_n = CW'(int'(len_q) + 2);
  assign bits_ld = bits_q + 5'd8;
  assign acc_ld  = acc_q | (19'(rdata) << bits_q);

  always_comb begin
    state_d = state_q; head_d = head_q; count_d = count_q; off_d = off_q;
    len_d = len_q; addr_d = addr_q; type_d = type_q; crc_d = crc_q;
    acc_d = acc_q; bits_d = bits_q; k_d = k_q; runs_d = runs_q;
    ov_d = ov_q; last_d = last_q; oidx_d = oidx_q; oval_d = oval_q;
    we = 1'b0; waddr = ptr(head_q, count_q); raddr = head_q;
    pop_o = 1'b0; drop_one = 1'b0; drop_frame = 1'b0;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          pop_o  = 1'b1;
          runs_d = 2'd0;
          if (int'(count_q) < BUFFER_BYTES) begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        raddr   = head_q;
        state_d = (count_q > CW'(1)) ? S_ADDR : S_IDLE;
      end
      S_ADDR: begin
        addr_d  = rdata;
        raddr   = ptr(head_q, CW'(1));
        state_d = S_LEN;
      end
      S_LEN: begin
        len_d = rdata;
        if (len_bad) begin
          drop_one = 1'b1;
          state_d  = S_SCAN;
        end else if (int'(count_q) >= int'(rdata) + 2) begin
          raddr   = ptr(head_q, CW'(2));
          off_d   = CW'(2);
          crc_d   = 8'd0;
          state_d = S_CRC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_CRC: begin
        crc_d = crc_byte(crc_q, rdata, cfg_i.crc_poly);
        if (off_q == CW'(2)) type_d = rdata;
        if (off_q == CW'(len_q)) begin
          raddr   = ptr(head_q, CW'(int'(len_q) + 1));
          state_d = S_CHK;
        end else begin
          raddr = ptr(head_q, off_q + CW'(1));
          off_d = off_q + CW'(1);
        end
      end
      S_CHK: begin
        state_d = S_SCAN;
        if (crc_q != rdata) begin
          drop_one = 1'b1;
        end else if (addr_q == cfg_i.rx_addr && type_q == cfg_i.ch_type
                     && int'(len_q) >= CH_BYTES + 2 && int'(runs_q) < MAX_RUNS) begin
          acc_d = '0; bits_d = '0; k_d = '0; off_d = CW'(3);
          state_d = S_EM_RD;
        end else begin
          drop_frame = 1'b1;
        end
      end
      S_EM_RD: begin
        raddr   = ptr(head_q, off_q);
        state_d = S_EM_LD;
      end
      S_EM_LD: begin
        acc_d   = acc_ld;
        bits_d  = bits_ld;
        off_d   = off_q + CW'(1);
        state_d = (int'(bits_ld) >= CH_BITS) ? S_EM_OUT : S_EM_RD;
      end
      S_EM_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d   = 1'b1;
          oidx_d = k_q;
          oval_d = acc_q[10:0];
          last_d = (int'(k_q) == NUM_CH - 1);
          acc_d  = acc_q >> CH_BITS;
          bits_d = bits_q - 5'(CH_BITS);
          k_d    = k_q + 4'd1;
          if (int'(k_q) == NUM_CH - 1) begin
            drop_frame = 1'b1;
            runs_d     = runs_q + 2'd1;
            state_d    = S_SCAN;
          end else if (int'(bits_q) - CH_BITS >= CH_BITS) begin
            state_d = S_EM_OUT;
          end else begin
            state_d = S_EM_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    drop_n = drop_frame ? frame_n : CW'(1);
    if (drop_one || drop_frame) begin
      if (drop_n >= count_q) begin
        count_d = '0;
      end else begin
        count_d = count_q - drop_n;
        head_d  = ptr(head_q, drop_n);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      runs_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      runs_q  <= runs_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q <= off_d; len_q <= len_d; addr_q <= addr_d; type_q <= type_d;
    crc_q <= crc_d; acc_q <= acc_d; bits_q <= bits_d; k_q <= k_d;
    last_q <= last_d; oidx_q <= oidx_d; oval_q <= oval_d;
  end

  assign out_valid_o     = ov_q;
  assign channel_index_o = oidx_q;
  assign channel_value_o = oval_q;
  assign last_channel_o  = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= BUFFER_BYTES) else $error("fill count beyond buffer");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && last_q |-> int'(oidx_q) == NUM_CH - 1) else $error("last flag off channel 15");
  a_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(runs_q) <= MAX_RUNS) else $error("too many channel runs");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == S_IDLE) else $error("byte taken mid scan");
endmodule
`default_nettype wire

/* test/rc_link_frame_parser_unit_tb.sv */
// Self-checking bench for rc_link_frame_parser_unit: byte stream in, channel
// transactions out, compared with an in-bench frame scanner. Needs rcfp_pkg.
`timescale 1ns / 100ps
module rc_link_frame_parser_unit_tb;
  import rcfp_pkg::*;

  localparam int BUF_BYTES = 64;
  localparam int MAX_PAY   = 60;
  localparam int MAX_OUT   = 32;
  localparam int LIMIT     = 2000000;

  typedef struct packed {
    logic [3:0]  idx;
    logic [10:0] value;
    logic        last;
  } chan_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_RX_ADDR;
  logic [7:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  channel_index_o;
  logic [10:0] channel_value_o;
  logic        last_channel_o;

  rc_link_frame_parser_unit i_dut (.*);

  always #10 clk_i = ~clk_i;

  // scanner mirror: buffer, fill and register copies
  logic [7:0] mirror_buf [BUF_BYTES];
  int         mirror_fill;
  cfg_t       mirror_cfg;

  logic [7:0] byte_queue [$];   // bytes waiting for the driver
  chan_t      chan_queue [$];   // channels predicted, not yet seen
  int         mismatches, chans_seen, bytes_sent, frames_good;
  int         cycles;
  bit         quiet_idle;       // stretch with no idling on either side
  int         hold_off;         // long receiver stall, in cycles
  bit         drained;
  logic       in_stall_o_q = 1'b1;

  function automatic logic [7:0] frame_crc(int start, int count);
    logic [7:0] c;
    c = '0;
    for (int i = 0; i < count; i++) begin
      c ^= (start + i < BUF_BYTES) ? mirror_buf[start + i] : 8'h00;
      for (int b = 0; b < 8; b++) begin
        c = c[7] ? ((c << 1) ^ mirror_cfg.crc_poly) : (c << 1);
      end
    end
    return c;
  endfunction

  function automatic void drop_bytes(int cnt);
    if (cnt >= mirror_fill) begin
      mirror_fill = 0;
    end else begin
      for (int i = 0; i < mirror_fill - cnt; i++) mirror_buf[i] = mirror_buf[i + cnt];
      mirror_fill -= cnt;
    end
  endfunction

  // append one byte, rescan, queue any channels that fall out
  function automatic void scan_byte(logic [7:0] b);
    int  n, len;
    bit  again;
    logic [31:0] acc;
    int  bits, pos;
    chan_t c;
    n = 0;
    if (mirror_fill < BUF_BYTES) begin
      mirror_buf[mirror_fill] = b;
      mirror_fill++;
    end
    do begin
      again = 1'b0;
      if (mirror_fill > 1) begin
        len = mirror_buf[1];
        if (len < MIN_LEN || len > MAX_PAY + 2 || len + 2 > BUF_BYTES) begin
          drop_bytes(1);
          again = 1'b1;
        end else if (mirror_fill >= len + 2) begin
          if (frame_crc(2, len - 1) == mirror_buf[len + 1]) begin
            frames_good++;
            if (mirror_buf[0] == mirror_cfg.rx_addr && mirror_buf[2] == mirror_cfg.ch_type &&
                len - 2 >= CH_BYTES && n < MAX_OUT) begin
              acc = 0; bits = 0; pos = 3;
              for (int k = 0; k < NUM_CH && n < MAX_OUT; k++) begin
                while (bits < CH_BITS) begin
                  acc |= 32'(mirror_buf[pos]) << bits;
                  bits += 8; pos++;
                end
                c.idx = 4'(k); c.value = acc[10:0]; c.last = (k == NUM_CH - 1);
                chan_queue.push_back(c);
                acc >>= CH_BITS; bits -= CH_BITS; n++;
              end
            end
            drop_bytes(len + 2);
          end else begin
            drop_bytes(1);
          end
          again = 1'b1;
        end
      end
    end while (again);
  endfunction

  // build a well-formed frame into the byte queue; crc spoiled on request
  function automatic void queue_frame(logic [7:0] addr, logic [7:0] ftype, int pay_len,
                                      bit bad_crc, bit max_fill);
    logic [7:0] body [$];
    logic [7:0] c;
    body.push_back(ftype);
    for (int i = 0; i < pay_len; i++)
      body.push_back(max_fill ? 8'hFF : 8'($urandom_range(0, 255)));
    c = '0;
    foreach (body[i]) begin
      c ^= body[i];
      for (int b = 0; b < 8; b++) c = c[7] ? ((c << 1) ^ mirror_cfg.crc_poly) : (c << 1);
    end
    if (bad_crc) c ^= 8'(1 << $urandom_range(0, 7));
    byte_queue.push_back(addr);
    byte_queue.push_back(8'(pay_len + 2));
    foreach (body[i]) byte_queue.push_back(body[i]);
    byte_queue.push_back(c);
  endfunction

  // driver: offers queued bytes, idles at random; mirror updated on acceptance
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o_q) begin
      scan_byte(rx_byte_i);
      bytes_sent++;
      void'(byte_queue.pop_front());
    end
    if (byte_queue.size() != 0 && (quiet_idle || $urandom_range(0, 99) >= 18)) begin
      in_valid_i <= 1'b1;
      rx_byte_i  <= byte_queue[0];
    end else if (!(in_valid_i && in_stall_o_q)) begin
      in_valid_i <= 1'b0;
    end
  end

  // acceptance flags sampled at the rising edge
  always @(posedge clk_i) in_stall_o_q <= in_stall_o;

  // receiver stall, including a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off    <= hold_off - 1;
    end else begin
      out_stall_i <= !quiet_idle && ($urandom_range(0, 99) < 18);
    end
  end

  // monitor: each channel transaction against the oldest prediction
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      chans_seen <= chans_seen + 1;
      if (chan_queue.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("unexpected channel idx=%0d value=%0d last=%0b",
                   channel_index_o, channel_value_o, last_channel_o);
      end else begin
        if (chan_queue[0] != {channel_index_o, channel_value_o, last_channel_o}) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("channel mismatch: exp idx=%0d value=%0d last=%0b, got %0d %0d %0b",
                     chan_queue[0].idx, chan_queue[0].value, chan_queue[0].last,
                     channel_index_o, channel_value_o, last_channel_o);
        end
        void'(chan_queue.pop_front());
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout with %0d channels outstanding", chan_queue.size());
      $display("FAIL rc_link_frame_parser_unit");
      $finish;
    end
  end

  task automatic wait_idle();
    while (byte_queue.size() != 0 || chan_queue.size() != 0) @(posedge clk_i);
    // the last bytes may still be rescanning: allow for a run of CRC drops
    // across a full buffer
    repeat (5000) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RX_ADDR:  mirror_cfg.rx_addr  = data;
      CFG_CH_TYPE:  mirror_cfg.ch_type  = data;
      CFG_CRC_POLY: mirror_cfg.crc_poly = data;
      default: ;
    endcase
  endtask

  // mostly good frames with random content, the rest noise and broken frames
  task automatic random_bytes(int count);
    int r;
    while (bytes_sent + byte_queue.size() < count) begin
      r = $urandom_range(0, 99);
      if (r < 55)
        queue_frame(mirror_cfg.rx_addr, mirror_cfg.ch_type,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(22, MAX_PAY) : CH_BYTES, 0, 0);
      else if (r < 65)
        queue_frame(mirror_cfg.rx_addr, mirror_cfg.ch_type, CH_BYTES, 1, 0);
      else if (r < 75)
        queue_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    $urandom_range(1, 30), 0, 0);
      else if (r < 82)
        queue_frame(mirror_cfg.rx_addr, mirror_cfg.ch_type, $urandom_range(1, 21), 0, 0);
      else
        repeat ($urandom_range(1, 6)) byte_queue.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  int target;

  initial begin
    mirror_fill = 0; mismatches = 0; chans_seen = 0; bytes_sent = 0; frames_good = 0;
    cycles = 0; quiet_idle = 0; hold_off = 0;
    mirror_cfg = '{rx_addr: 8'd200, ch_type: 8'd22, crc_poly: 8'd213};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // directed: all-ones channels, short frame, bad length bytes, bad crc,
    // foreign address, longest payload, and two frames in one burst
    queue_frame(8'd200, 8'd22, CH_BYTES, 0, 1);
    queue_frame(8'd200, 8'd22, 8'd5, 0, 0);
    byte_queue.push_back(8'h00); byte_queue.push_back(8'h02);
    byte_queue.push_back(8'hC8); byte_queue.push_back(8'd63);
    queue_frame(8'd200, 8'd22, CH_BYTES, 1, 0);
    queue_frame(8'd7, 8'd22, CH_BYTES, 0, 0);
    queue_frame(8'd200, 8'd22, MAX_PAY, 0, 0);
    queue_frame(8'd200, 8'd22, CH_BYTES, 0, 0);
    wait_idle();

    // register extremes, the unused index included
    write_reg(CFG_RX_ADDR, 8'h00); write_reg(CFG_CH_TYPE, 8'hFF);
    write_reg(CFG_CRC_POLY, 8'h00); write_reg(2'd3, 8'hA5);
    target = bytes_sent + 20;
    random_bytes(target);
    wait_idle();

    write_reg(CFG_RX_ADDR, 8'hFF); write_reg(CFG_CH_TYPE, 8'h00);
    write_reg(CFG_CRC_POLY, 8'hFF);
    // receiver held off while frames keep coming, so the input backs up
    hold_off = 400;
    random_bytes(bytes_sent + 25);
    wait_idle();
    // a stretch with no idling on either side
    quiet_idle = 1;
    random_bytes(bytes_sent + 25);
    wait_idle();
    quiet_idle = 0;

    write_reg(CFG_RX_ADDR, 8'($urandom_range(0, 255)));
    write_reg(CFG_CH_TYPE, 8'($urandom_range(0, 255)));
    write_reg(CFG_CRC_POLY, 8'($urandom_range(0, 255)));
    random_bytes(bytes_sent + 15);
    wait_idle();

    $display("covered %0d bytes, %0d good frames, %0d channels checked",
             bytes_sent, frames_good, chans_seen);
    if (mismatches == 0) begin
      $display("PASS rc_link_frame_parser_unit");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL rc_link_frame_parser_unit");
    end
    $finish;
  end

endmodule
